/* hdl/rrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types, geometry constants and helpers for the rotated RGB555 blit.
// ----------------------------------------------------------------------------
package rrb_pkg;

    // Output geometry
    localparam int OUT_WIDTH   = 320;
    localparam int OUT_HEIGHT  = 240;
    localparam int LEFT_MARGIN = 40;
    localparam int FB_HEIGHT   = 240;
    localparam int BYTES_PX    = 3;

    // Source row selection
    localparam int SCALE_NUM  = 256;
    localparam int SCALE_DEN  = 240;
    localparam int SCALE_INT  = SCALE_NUM / SCALE_DEN;
    localparam int SCALE_FRAC = SCALE_NUM % SCALE_DEN;
    localparam int CROP_SKIP  = 8;
    localparam int MAX_PITCH  = 1024;
    localparam int ROW_MAX    = 511;

    // Field and counter widths
    localparam int PIX_W   = 16;
    localparam int PITCH_W = 11;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int OROW_W  = 8;
    localparam int FRAC_W  = 8;
    localparam int OFF_W   = 19;
    localparam int RTERM_W = 10;

    // Incremental offset terms: offset = col_base + row_term
    localparam int COL_STEP   = FB_HEIGHT * BYTES_PX;
    localparam int COL_BASE0  = LEFT_MARGIN * COL_STEP;
    localparam int ROW_TERM0  = (FB_HEIGHT - 1) * BYTES_PX;
    localparam int FB_BYTES   = (OUT_WIDTH + 2 * LEFT_MARGIN) * FB_HEIGHT * BYTES_PX;

    // APB register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_CROP_MODE = 1'b0;
    localparam logic REG_ROW_PITCH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } rrb_in_t;

    typedef struct packed {
        logic [OFF_W-1:0] fb_offset;
        logic [7:0]       blue_byte;
        logic [7:0]       green_byte;
        logic [7:0]       red_byte;
        logic             frame_done;
    } rrb_out_t;

    typedef struct packed {
        logic               crop_mode;
        logic [PITCH_W-1:0] row_pitch;
    } rrb_cfg_t;

    // Stage between the raster walker and the output register
    typedef struct packed {
        logic [PIX_W-2:0] pixel;
        logic [OFF_W-1:0] fb_offset;
        logic             frame_done;
    } rrb_stage_t;

    // 5-bit to 8-bit by replicating the top bits
    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

/* hdl/rrb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_regs
// APB configuration registers: crop mode and source row pitch.
// ----------------------------------------------------------------------------
module rrb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrb_pkg::PADDR_W-1:0] paddr,
    input  logic [rrb_pkg::PDATA_W-1:0] pwdata,
    output logic [rrb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output rrb_pkg::rrb_cfg_t           cfg
);
    import rrb_pkg::*;

    logic               crop_mode_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crop_mode_reg <= 1'b0;
            row_pitch_reg <= PITCH_W'(MAX_PITCH);
        end else if (wr_en) begin
            case (reg_sel)
                REG_CROP_MODE: crop_mode_reg <= pwdata[0];
                REG_ROW_PITCH: row_pitch_reg <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_sel)
            REG_CROP_MODE: prdata = {{(PDATA_W-1){1'b0}}, crop_mode_reg};
            REG_ROW_PITCH: prdata = {{(PDATA_W-PITCH_W){1'b0}}, row_pitch_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.crop_mode = crop_mode_reg;
    assign cfg.row_pitch = row_pitch_reg;

endmodule

/* hdl/rrb_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_walk
// Raster walker: tracks source column/row and output row, picks the kept
// pixels and builds their framebuffer offsets incrementally.
// ----------------------------------------------------------------------------
module rrb_walk (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrb_pkg::rrb_cfg_t   cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrb_pkg::rrb_in_t    s_data,
    input  logic                adv,
    output logic                a_valid,
    output rrb_pkg::rrb_stage_t a_stage
);
    import rrb_pkg::*;

    // Counter state
    logic [COL_W-1:0]   col_reg,   col_next;
    logic [ROW_W-1:0]   srow_reg,  srow_next;
    logic [OROW_W-1:0]  orow_reg,  orow_next;
    logic [ROW_W-1:0]   map_reg,   map_next;
    logic [FRAC_W-1:0]  frac_reg,  frac_next;
    logic [OFF_W-1:0]   cbase_reg, cbase_next;
    logic [RTERM_W-1:0] rterm_reg, rterm_next;

    // Stage register
    logic       a_valid_reg, a_valid_next;
    rrb_stage_t a_stage_reg, a_stage_next;

    // Current values, restarted by frame start
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   srow_cur;
    logic [OROW_W-1:0]  orow_cur;
    logic [ROW_W-1:0]   map_cur;
    logic [FRAC_W-1:0]  frac_cur;
    logic [OFF_W-1:0]   cbase_cur;
    logic [RTERM_W-1:0] rterm_cur;

    logic [PITCH_W-1:0] pitch_eff;
    logic [PITCH_W-1:0] used;
    logic [ROW_W-1:0]   map_sel;
    logic [FRAC_W:0]    frac_sum;
    logic               frac_carry;
    logic               kept;
    logic               col_in;
    logic               row_end;
    logic               accept;

    assign s_ready = !a_valid_reg || adv;
    assign accept  = s_valid && s_ready;

    // Effective pitch and used width
    always_comb begin
        if (cfg.row_pitch == '0 || cfg.row_pitch > PITCH_W'(MAX_PITCH)) begin
            pitch_eff = PITCH_W'(MAX_PITCH);
        end else begin
            pitch_eff = cfg.row_pitch;
        end
        used = (pitch_eff < PITCH_W'(OUT_WIDTH)) ? pitch_eff : PITCH_W'(OUT_WIDTH);
    end

    // Frame start restarts all counters
    always_comb begin
        if (s_data.frame_start) begin
            col_cur   = '0;
            srow_cur  = '0;
            orow_cur  = '0;
            map_cur   = '0;
            frac_cur  = '0;
            cbase_cur = OFF_W'(COL_BASE0);
            rterm_cur = RTERM_W'(ROW_TERM0);
        end else begin
            col_cur   = col_reg;
            srow_cur  = srow_reg;
            orow_cur  = orow_reg;
            map_cur   = map_reg;
            frac_cur  = frac_reg;
            cbase_cur = cbase_reg;
            rterm_cur = rterm_reg;
        end
    end

    // Row selection and pixel use
    assign map_sel = cfg.crop_mode ? (ROW_W'(orow_cur) + ROW_W'(CROP_SKIP)) : map_cur;
    assign kept    = (orow_cur < OROW_W'(OUT_HEIGHT)) && (srow_cur == map_sel);
    assign col_in  = {1'b0, col_cur} < used;
    assign row_end = ({1'b0, col_cur} + PITCH_W'(1)) >= pitch_eff;

    // Scaled row mapping steps by 256/240 per output row
    assign frac_sum   = {1'b0, frac_cur} + (FRAC_W+1)'(SCALE_FRAC);
    assign frac_carry = frac_sum >= (FRAC_W+1)'(SCALE_DEN);

    // Next counter values
    always_comb begin
        col_next   = col_reg;
        srow_next  = srow_reg;
        orow_next  = orow_reg;
        map_next   = map_reg;
        frac_next  = frac_reg;
        cbase_next = cbase_reg;
        rterm_next = rterm_reg;
        if (accept) begin
            srow_next  = srow_cur;
            orow_next  = orow_cur;
            map_next   = map_cur;
            frac_next  = frac_cur;
            rterm_next = rterm_cur;
            if (row_end) begin
                col_next   = '0;
                cbase_next = OFF_W'(COL_BASE0);
                if (kept) begin
                    orow_next  = orow_cur + OROW_W'(1);
                    rterm_next = rterm_cur - RTERM_W'(BYTES_PX);
                    map_next   = map_cur + ROW_W'(SCALE_INT) + ROW_W'(frac_carry);
                    frac_next  = frac_carry ? FRAC_W'(frac_sum - (FRAC_W+1)'(SCALE_DEN))
                                            : FRAC_W'(frac_sum);
                end
                if (srow_cur < ROW_W'(ROW_MAX)) begin
                    srow_next = srow_cur + ROW_W'(1);
                end
            end else begin
                col_next   = col_cur + COL_W'(1);
                cbase_next = cbase_cur + OFF_W'(COL_STEP);
            end
        end
    end

    // Stage register load
    always_comb begin
        a_valid_next = a_valid_reg;
        a_stage_next = a_stage_reg;
        if (accept) begin
            a_valid_next            = kept && col_in;
            a_stage_next.pixel      = s_data.pixel[PIX_W-2:0];
            a_stage_next.fb_offset  = cbase_cur + OFF_W'(rterm_cur);
            a_stage_next.frame_done = (orow_cur == OROW_W'(OUT_HEIGHT - 1)) &&
                                      ({1'b0, col_cur} == used - PITCH_W'(1));
        end else if (adv) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            srow_reg    <= '0;
            orow_reg    <= '0;
            map_reg     <= '0;
            frac_reg    <= '0;
            cbase_reg   <= OFF_W'(COL_BASE0);
            rterm_reg   <= RTERM_W'(ROW_TERM0);
            a_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            srow_reg    <= srow_next;
            orow_reg    <= orow_next;
            map_reg     <= map_next;
            frac_reg    <= frac_next;
            cbase_reg   <= cbase_next;
            rterm_reg   <= rterm_next;
            a_valid_reg <= a_valid_next;
        end
        a_stage_reg <= a_stage_next;
    end

    assign a_valid = a_valid_reg;
    assign a_stage = a_stage_reg;

endmodule

/* hdl/rrb_outreg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_outreg
// Result register: widens the color fields and holds the request until
// the receiver takes it.
// ----------------------------------------------------------------------------
module rrb_outreg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                a_valid,
    input  rrb_pkg::rrb_stage_t a_stage,
    output logic                adv,
    output logic                m_valid,
    input  logic                m_ready,
    output rrb_pkg::rrb_out_t   m_data
);
    import rrb_pkg::*;

    logic     m_valid_reg, m_valid_next;
    rrb_out_t m_data_reg,  m_data_next;

    // Register is free when empty or being drained
    assign adv = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv) begin
            m_valid_next = a_valid;
            if (a_valid) begin
                m_data_next.fb_offset  = a_stage.fb_offset;
                m_data_next.blue_byte  = expand5(a_stage.pixel[14:10]);
                m_data_next.green_byte = expand5(a_stage.pixel[9:5]);
                m_data_next.red_byte   = expand5(a_stage.pixel[4:0]);
                m_data_next.frame_done = a_stage.frame_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/rotated_rgb555_blit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rgb555_blit_top
// RGB555 raster in, rotated BGR8 framebuffer writes out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes source pixels in raster order, one per request; frame_start
//   marks the first pixel of a frame and clears the raster counters.
//   m_* gives one request per kept pixel: its byte offset in the rotated
//   400x240 BGR8 framebuffer and the widened B, G, R bytes; frame_done
//   flags the last pixel written for the frame. Skipped pixels give none.
//   The APB port holds crop_mode (0x0) and row_pitch (0x4); change them
//   only while the block is idle.
// Timing:
//   One pixel per clock sustained while m_ready holds high. A result on m_*
//   passes through the raster walker stage register and then the result
//   register. The offset is an add of two running terms.
// Reset and stall:
//   Reset clears the counters, drops m_valid and loads crop_mode=0,
//   row_pitch=1024. When m_ready is low the result holds; pixels are still
//   taken until one that gives a result sits in the stage register, and
//   s_ready then drops.
// ----------------------------------------------------------------------------
module rotated_rgb555_blit_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrb_pkg::PADDR_W-1:0] paddr,
    input  logic [rrb_pkg::PDATA_W-1:0] pwdata,
    output logic [rrb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rrb_pkg::rrb_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rrb_pkg::rrb_out_t           m_data
);
    import rrb_pkg::*;

    rrb_cfg_t   cfg;
    logic       a_valid;
    rrb_stage_t a_stage;
    logic       adv;

    rrb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrb_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .adv     (adv),
        .a_valid (a_valid),
        .a_stage (a_stage)
    );

    rrb_outreg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_valid (a_valid),
        .a_stage (a_stage),
        .adv     (adv),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hdl/rrb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_checker
// Port-level checks for the rotated RGB555 blit, bound to the top level.
// ----------------------------------------------------------------------------
module rrb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        pready,
    input logic                        m_valid,
    input logic                        m_ready,
    input rrb_pkg::rrb_out_t           m_data
);
    import rrb_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Offsets stay inside the framebuffer
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.fb_offset < OFF_W'(FB_BYTES))
        else $error("offset past framebuffer");

    // Last pixel lands on the top byte of its rotated column
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> (m_data.fb_offset % OFF_W'(COL_STEP)) == '0)
        else $error("frame_done on a pixel that is not in the last output row");

    // APB never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("pready low");

endmodule

bind rotated_rgb555_blit_top rrb_checker u_rrb_checker (.*);

/* sim/rotated_rgb555_blit_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rgb555_blit_top_tb
// Streams RGB555 rasters through the blit under several crop/pitch settings
// and checks every framebuffer write against an in-bench row/column tracker,
// with random idle bursts on both channels and one long result-side stall.
// ----------------------------------------------------------------------------
module rotated_rgb555_blit_top_tb;
    import rrb_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int HOLD_AT    = 150;    // accepted pixels before the long stall
    localparam int HOLD_LEN   = 48;
    localparam int SETTLE_CYC = 6;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rrb_in_t              s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rrb_out_t             m_data;

    rrb_in_t  pixel_queue[$];
    rrb_out_t fb_writes_due[$];

    // Raster tracker and shadow registers
    logic [COL_W-1:0]   col_ctr   = '0;
    logic [ROW_W-1:0]   srow_ctr  = '0;
    logic [OROW_W-1:0]  orow_ctr  = '0;
    logic               cfg_crop  = 1'b0;
    logic [PITCH_W-1:0] cfg_pitch = PITCH_W'(MAX_PITCH);

    int err_count   = 0;
    int taken_count = 0;
    int tx_gap      = 0;
    int rx_gap      = 0;
    int hold_left   = 0;
    bit hold_fired  = 1'b0;
    bit calm        = 1'b0;

    rotated_rgb555_blit_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // 5-bit channel to 8 bits, top bits repeated into the low end
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return (8'(v) << 3) | (8'(v) >> 2);
    endfunction

    // Advance the raster counters by one pixel and queue its write, if any
    function automatic void blit_pixel(input rrb_in_t px);
        int unsigned pitch;
        int unsigned used;
        int unsigned src_pick;
        int unsigned off;
        bit          kept;
        rrb_out_t    wr;
        pitch = (cfg_pitch == 0 || cfg_pitch > MAX_PITCH) ? MAX_PITCH : cfg_pitch;
        used  = (pitch < OUT_WIDTH) ? pitch : OUT_WIDTH;
        if (px.frame_start) begin
            col_ctr  = '0;
            srow_ctr = '0;
            orow_ctr = '0;
        end
        src_pick = cfg_crop ? orow_ctr + CROP_SKIP : (orow_ctr * SCALE_NUM) / SCALE_DEN;
        kept = (orow_ctr < OUT_HEIGHT) && (srow_ctr == src_pick);
        if (kept && col_ctr < used) begin
            off = ((LEFT_MARGIN + col_ctr) * FB_HEIGHT + FB_HEIGHT - 1 - orow_ctr)
                  * BYTES_PX;
            wr.fb_offset  = off[OFF_W-1:0];
            wr.blue_byte  = widen5(px.pixel[14:10]);
            wr.green_byte = widen5(px.pixel[9:5]);
            wr.red_byte   = widen5(px.pixel[4:0]);
            wr.frame_done = (orow_ctr == OUT_HEIGHT - 1) && (col_ctr == used - 1);
            fb_writes_due.push_back(wr);
        end
        if (col_ctr + 1 >= pitch) begin
            col_ctr = '0;
            if (kept)
                orow_ctr = orow_ctr + 1'b1;
            if (srow_ctr < ROW_MAX)
                srow_ctr = srow_ctr + 1'b1;
        end else begin
            col_ctr = col_ctr + 1'b1;
        end
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_fb_write(input rrb_out_t got);
        rrb_out_t want;
        if (fb_writes_due.size() == 0) begin
            flag_mismatch("write with none pending, fb_offset", got.fb_offset, -1);
        end else begin
            want = fb_writes_due.pop_front();
            if (got.fb_offset != want.fb_offset)
                flag_mismatch("fb_offset", got.fb_offset, want.fb_offset);
            if (got.blue_byte != want.blue_byte)
                flag_mismatch("blue_byte", got.blue_byte, want.blue_byte);
            if (got.green_byte != want.green_byte)
                flag_mismatch("green_byte", got.green_byte, want.green_byte);
            if (got.red_byte != want.red_byte)
                flag_mismatch("red_byte", got.red_byte, want.red_byte);
            if (got.frame_done != want.frame_done)
                flag_mismatch("frame_done", got.frame_done, want.frame_done);
        end
    endtask

    // Pixel driver: tracks accepted requests, idles in short bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                blit_pixel(s_data);
                taken_count <= taken_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 15) == 0) begin
                    tx_gap  <= $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    s_data  <= pixel_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long result-side stall, fired once mid-frame
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_fired && taken_count >= HOLD_AT) begin
            hold_left  <= HOLD_LEN;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Write monitor: checks accepted requests, stalls in short bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (m_valid && m_ready)
                check_fb_write(m_data);
            if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                rx_gap  <= $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic reg_idx, input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_CROP_MODE)
            cfg_crop = value[0];
        else
            cfg_pitch = value[PITCH_W-1:0];
    endtask

    // Nothing queued, nothing in flight, every write seen
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_valid || fb_writes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic queue_px(input logic [PIX_W-1:0] p, input logic fs);
        rrb_in_t px;
        px.pixel       = p;
        px.frame_start = fs;
        pixel_queue.push_back(px);
    endtask

    task automatic run_phase(input logic crop, input int pitch, input int count,
                             input int restart_pct);
        rrb_in_t px;
        wait_idle();
        apb_write(REG_CROP_MODE, PDATA_W'(crop));
        apb_write(REG_ROW_PITCH, PDATA_W'(pitch));
        @(negedge aclk);
        for (int i = 0; i < count; i++) begin
            px.pixel       = PIX_W'($urandom_range(0, 16'hFFFF));
            px.frame_start = (i == 0) || ($urandom_range(0, 99) < restart_pct);
            pixel_queue.push_back(px);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: row 0 is kept, every pixel writes
        queue_px(16'h0000, 1'b1);
        queue_px(16'hFFFF, 1'b0);
        queue_px(16'h7FFF, 1'b0);
        queue_px(16'h8000, 1'b0);   // only the ignored top bit set
        queue_px(16'h001F, 1'b0);
        queue_px(16'h03E0, 1'b0);
        queue_px(16'h7C00, 1'b0);
        queue_px(16'h0421, 1'b0);
        queue_px(16'h8421, 1'b0);
        queue_px(16'h7BDE, 1'b0);
        queue_px(16'h5294, 1'b0);
        queue_px(16'h2D6B, 1'b0);
        queue_px(16'h0010, 1'b0);
        queue_px(16'h0200, 1'b0);
        queue_px(16'h4000, 1'b0);
        queue_px(16'hFFFF, 1'b1);   // restart mid-row
        queue_px(16'h1234, 1'b0);
        queue_px(16'hABCD, 1'b0);
        queue_px(16'h8000, 1'b1);
        queue_px(16'h7FFF, 1'b0);

        // One pixel per row in crop mode: first rows dropped, then kept
        run_phase(1'b1, 1, 16, 0);
        // Whole scaled frame, with skipped source rows; long stall lands here
        run_phase(1'b0, 1, 262, 0);
        // Zero pitch reads as full width, random restarts
        run_phase(1'b0, 0, 40, 4);
        // Oversized pitch in crop mode: first rows are all dropped
        run_phase(1'b1, 2047, 24, 0);
        run_phase(1'b0, 2, 40, 5);

        wait_idle();
        @(negedge aclk);
        calm = 1'b1;
        // Short rows in crop mode, no idling on either side
        run_phase(1'b1, 3, 40, 0);
        wait_idle();

        if (err_count == 0)
            $display("rotated_rgb555_blit_top_tb: clean");
        else
            $display("rotated_rgb555_blit_top_tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("rotated_rgb555_blit_top_tb: errors");
        $finish;
    end

endmodule

/* rotated_rgb555_blit_top.f */
hdl/rrb_pkg.sv
hdl/rrb_regs.sv
hdl/rrb_walk.sv
hdl/rrb_outreg.sv
hdl/rotated_rgb555_blit_top.sv
hdl/rrb_checker.sv
sim/rotated_rgb555_blit_top_tb.sv
